/* rtl/pit_pkg.sv */
// ----------------------------------------------------------------------------
// pit_pkg
// Pipeline stage indexes and result type for the point-in-triangle test.
// ----------------------------------------------------------------------------
package pit_pkg;

  // pipeline stages, in order
  localparam int unsigned StDiff    = 0;
  localparam int unsigned StProd    = 1;
  localparam int unsigned StDot     = 2;
  localparam int unsigned StPart    = 3;
  localparam int unsigned StWide    = 4;
  localparam int unsigned StNumer   = 5;
  localparam int unsigned StSum     = 6;
  localparam int unsigned StOut     = 7;
  localparam int unsigned NumStages = 8;

  typedef struct packed {
    logic in_tri;
    logic degenerate;
  } res_t;

endpackage

/* rtl/pit_dot.sv */
// ----------------------------------------------------------------------------
// pit_dot
// Edge vectors, coordinate products and the five dot products (three stages).
// ----------------------------------------------------------------------------
module pit_dot #(
  parameter int unsigned CW = 16,
  parameter int unsigned DW = 2 * CW + 4
) (
  input  logic                             clk_i,
  input  logic [pit_pkg::NumStages-1:0]    en_i,
  input  logic signed [CW-1:0]             p_i [3],
  input  logic signed [CW-1:0]             a_i [3],
  input  logic signed [CW-1:0]             b_i [3],
  input  logic signed [CW-1:0]             c_i [3],
  output logic signed [DW-1:0]             uu_o,
  output logic signed [DW-1:0]             uv_o,
  output logic signed [DW-1:0]             vv_o,
  output logic signed [DW-1:0]             wu_o,
  output logic signed [DW-1:0]             wv_o
);
  import pit_pkg::*;

  localparam int unsigned DFW = CW + 1;
  localparam int unsigned PRW = 2 * DFW;

  logic signed [DFW-1:0] u_q [3];
  logic signed [DFW-1:0] v_q [3];
  logic signed [DFW-1:0] w_q [3];

  logic signed [PRW-1:0] uu_q [3];
  logic signed [PRW-1:0] uv_q [3];
  logic signed [PRW-1:0] vv_q [3];
  logic signed [PRW-1:0] wu_q [3];
  logic signed [PRW-1:0] wv_q [3];

  logic signed [DW-1:0] uu_dq, uv_dq, vv_dq, wu_dq, wv_dq;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en_i[StDiff]) begin
        u_q[i] <= DFW'(b_i[i]) - DFW'(a_i[i]);
        v_q[i] <= DFW'(c_i[i]) - DFW'(a_i[i]);
        w_q[i] <= DFW'(p_i[i]) - DFW'(a_i[i]);
      end
      if (en_i[StProd]) begin
        uu_q[i] <= PRW'(u_q[i]) * PRW'(u_q[i]);
        uv_q[i] <= PRW'(u_q[i]) * PRW'(v_q[i]);
        vv_q[i] <= PRW'(v_q[i]) * PRW'(v_q[i]);
        wu_q[i] <= PRW'(w_q[i]) * PRW'(u_q[i]);
        wv_q[i] <= PRW'(w_q[i]) * PRW'(v_q[i]);
      end
    end
    if (en_i[StDot]) begin
      uu_dq <= DW'(uu_q[0]) + DW'(uu_q[1]) + DW'(uu_q[2]);
      uv_dq <= DW'(uv_q[0]) + DW'(uv_q[1]) + DW'(uv_q[2]);
      vv_dq <= DW'(vv_q[0]) + DW'(vv_q[1]) + DW'(vv_q[2]);
      wu_dq <= DW'(wu_q[0]) + DW'(wu_q[1]) + DW'(wu_q[2]);
      wv_dq <= DW'(wv_q[0]) + DW'(wv_q[1]) + DW'(wv_q[2]);
    end
  end

  assign uu_o = uu_dq;
  assign uv_o = uv_dq;
  assign vv_o = vv_dq;
  assign wu_o = wu_dq;
  assign wv_o = wv_dq;

endmodule

/* rtl/pit_wmul.sv */
// ----------------------------------------------------------------------------
// pit_wmul
// Wide signed multiplier: four half-width partial products, then the sum.
// ----------------------------------------------------------------------------
module pit_wmul #(
  parameter int unsigned DW = 36
) (
  input  logic                             clk_i,
  input  logic [pit_pkg::NumStages-1:0]    en_i,
  input  logic signed [DW-1:0]             a_i,
  input  logic signed [DW-1:0]             b_i,
  output logic signed [2*DW-1:0]           p_o
);
  import pit_pkg::*;

  localparam int unsigned K  = DW / 2;
  localparam int unsigned HW = DW - K;
  localparam int unsigned PW = 2 * DW;

  logic signed [HW-1:0]     a_hi, b_hi;
  logic signed [K:0]        a_lo, b_lo;
  logic        [K-1:0]      a_lu, b_lu;

  logic signed [2*HW-1:0]   hh_q;
  logic signed [HW+K:0]     hl_q, lh_q;
  logic        [2*K-1:0]    ll_q;
  logic signed [PW-1:0]     p_q;
  logic signed [PW-1:0]     p_d;

  always_comb begin
    a_hi = $signed(a_i[DW-1:K]);
    b_hi = $signed(b_i[DW-1:K]);
    a_lu = a_i[K-1:0];
    b_lu = b_i[K-1:0];
    a_lo = $signed({1'b0, a_lu});
    b_lo = $signed({1'b0, b_lu});
    p_d  = (PW'(hh_q) <<< (2 * K))
         + ((PW'(hl_q) + PW'(lh_q)) <<< K)
         + $signed(PW'(ll_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StPart]) begin
      hh_q <= (2*HW)'(a_hi) * (2*HW)'(b_hi);
      hl_q <= (HW+K+1)'(a_hi) * (HW+K+1)'(b_lo);
      lh_q <= (HW+K+1)'(a_lo) * (HW+K+1)'(b_hi);
      ll_q <= (2*K)'(a_lu) * (2*K)'(b_lu);
    end
    if (en_i[StWide]) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/pit_decide.sv */
// ----------------------------------------------------------------------------
// pit_decide
// Barycentric numerators, denominator and the sign-adjusted inside test.
// ----------------------------------------------------------------------------
module pit_decide #(
  parameter int unsigned PW = 72
) (
  input  logic                             clk_i,
  input  logic [pit_pkg::NumStages-1:0]    en_i,
  input  logic signed [PW-1:0]             uvuv_i,
  input  logic signed [PW-1:0]             uuvv_i,
  input  logic signed [PW-1:0]             uvwv_i,
  input  logic signed [PW-1:0]             vvwu_i,
  input  logic signed [PW-1:0]             uvwu_i,
  input  logic signed [PW-1:0]             uuwv_i,
  output pit_pkg::res_t                    res_o
);
  import pit_pkg::*;

  localparam int unsigned NW = PW + 1;
  localparam int unsigned SW = NW + 1;

  logic signed [NW-1:0] d_q, sn_q, tn_q;

  logic signed [SW-1:0] sum_q, den_q;
  logic                 degen_q, dneg_q;
  logic                 sn_neg_q, sn_zero_q, tn_neg_q, tn_zero_q;

  logic                 pos_ok, neg_ok;
  res_t                 res_d, res_q;

  always_comb begin
    pos_ok = !sn_neg_q && !tn_neg_q && (sum_q <= den_q);
    neg_ok = (sn_neg_q || sn_zero_q) && (tn_neg_q || tn_zero_q) && (sum_q >= den_q);
    res_d.degenerate = degen_q;
    res_d.in_tri     = !degen_q && (dneg_q ? neg_ok : pos_ok);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StNumer]) begin
      d_q  <= NW'(uvuv_i) - NW'(uuvv_i);
      sn_q <= NW'(uvwv_i) - NW'(vvwu_i);
      tn_q <= NW'(uvwu_i) - NW'(uuwv_i);
    end
    if (en_i[StSum]) begin
      sum_q     <= SW'(sn_q) + SW'(tn_q);
      den_q     <= SW'(d_q);
      degen_q   <= (d_q == '0);
      dneg_q    <= d_q[NW-1];
      sn_neg_q  <= sn_q[NW-1];
      sn_zero_q <= (sn_q == '0);
      tn_neg_q  <= tn_q[NW-1];
      tn_zero_q <= (tn_q == '0);
    end
    if (en_i[StOut]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/point_in_triangle_test.sv */
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Exact barycentric point-in-triangle test on signed integer coordinates.
// One test enters per clock unless in_stall_o is high; its result passes
// through the eight register stages (edge vectors, coordinate products,
// dot sums, half-width partial products of the wide multipliers, their sum,
// numerators, sign flags and sum, output register). A stalled output only
// holds the stages that are full, so bubbles close up behind it. Points on
// an edge count as inside; a zero denominator reports degenerate and outside.
// ----------------------------------------------------------------------------
module point_in_triangle_test #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o,
  output logic                          degenerate_o
);
  import pit_pkg::*;

  localparam int unsigned DW = 2 * COORD_WIDTH + 4;
  localparam int unsigned PW = 2 * DW;

  logic [NumStages-1:0] valid_q, valid_d, en;

  logic signed [COORD_WIDTH-1:0] p [3];
  logic signed [COORD_WIDTH-1:0] a [3];
  logic signed [COORD_WIDTH-1:0] b [3];
  logic signed [COORD_WIDTH-1:0] c [3];

  logic signed [DW-1:0] uu, uv, vv, wu, wv;
  logic signed [PW-1:0] uvuv, uuvv, uvwv, vvwu, uvwu, uuwv;
  res_t                 res;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    en[StOut] = !valid_q[StOut] || !out_stall_i;
    for (int k = StOut - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k + 1];
    end
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = en[k] ? valid_q[k - 1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign p = '{point_x_i, point_y_i, point_z_i};
  assign a = '{vertex_a_x_i, vertex_a_y_i, vertex_a_z_i};
  assign b = '{vertex_b_x_i, vertex_b_y_i, vertex_b_z_i};
  assign c = '{vertex_c_x_i, vertex_c_y_i, vertex_c_z_i};

  pit_dot #(
    .CW (COORD_WIDTH),
    .DW (DW)
  ) u_dot (
    .clk_i (clk_i),
    .en_i  (en),
    .p_i   (p),
    .a_i   (a),
    .b_i   (b),
    .c_i   (c),
    .uu_o  (uu),
    .uv_o  (uv),
    .vv_o  (vv),
    .wu_o  (wu),
    .wv_o  (wv)
  );

  pit_wmul #(.DW (DW)) u_mul_uvuv (
    .clk_i (clk_i), .en_i (en), .a_i (uv), .b_i (uv), .p_o (uvuv)
  );
  pit_wmul #(.DW (DW)) u_mul_uuvv (
    .clk_i (clk_i), .en_i (en), .a_i (uu), .b_i (vv), .p_o (uuvv)
  );
  pit_wmul #(.DW (DW)) u_mul_uvwv (
    .clk_i (clk_i), .en_i (en), .a_i (uv), .b_i (wv), .p_o (uvwv)
  );
  pit_wmul #(.DW (DW)) u_mul_vvwu (
    .clk_i (clk_i), .en_i (en), .a_i (vv), .b_i (wu), .p_o (vvwu)
  );
  pit_wmul #(.DW (DW)) u_mul_uvwu (
    .clk_i (clk_i), .en_i (en), .a_i (uv), .b_i (wu), .p_o (uvwu)
  );
  pit_wmul #(.DW (DW)) u_mul_uuwv (
    .clk_i (clk_i), .en_i (en), .a_i (uu), .b_i (wv), .p_o (uuwv)
  );

  pit_decide #(
    .PW (PW)
  ) u_decide (
    .clk_i  (clk_i),
    .en_i   (en),
    .uvuv_i (uvuv),
    .uuvv_i (uuvv),
    .uvwv_i (uvwv),
    .vvwu_i (vvwu),
    .uvwu_i (uvwu),
    .uuwv_i (uuwv),
    .res_o  (res)
  );

  assign in_stall_o   = !en[0];
  assign out_valid_o  = valid_q[StOut];
  assign inside_res_o = res.in_tri;
  assign degenerate_o = res.degenerate;

endmodule
